// File: hw/rtl/omt_pkg.sv
// shared types and constants for the os match timer block
`default_nettype none

package omt_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned NumMatch = 4;
  localparam int unsigned MatchIdxW = $clog2(NumMatch);

  localparam logic [NumMatch-1:0] LOW4_MASK = 4'hF;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_READ   = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_SW_RST = 2'd3
  } mode_t;

  localparam logic [2:0] REG_MATCH0 = 3'd0;
  localparam logic [2:0] REG_MATCH1 = 3'd1;
  localparam logic [2:0] REG_MATCH2 = 3'd2;
  localparam logic [2:0] REG_MATCH3 = 3'd3;
  localparam logic [2:0] REG_COUNT  = 3'd4;
  localparam logic [2:0] REG_STATUS = 3'd5;
  localparam logic [2:0] REG_WDOG   = 3'd6;
  localparam logic [2:0] REG_IRQ_EN = 3'd7;

  typedef struct packed {
    mode_t             mode;
    logic [2:0]        reg_index;
    logic [DataW-1:0]  write_data;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0]    read_data;
    logic [NumMatch-1:0] match_status;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/omt_regs.sv
// timer register file: counter, match registers, status, enables and item decode
`default_nettype none

module omt_regs (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           item_fire,
  input  wire omt_pkg::item_t item,
  output omt_pkg::result_t    result
);

  logic [omt_pkg::DataW-1:0]    count_r, count_nxt;
  logic [omt_pkg::DataW-1:0]    match_r   [omt_pkg::NumMatch];
  logic [omt_pkg::DataW-1:0]    match_nxt [omt_pkg::NumMatch];
  logic [omt_pkg::NumMatch-1:0] status_r, status_nxt;
  logic [omt_pkg::NumMatch-1:0] irq_en_r, irq_en_nxt;
  logic                         wdog_r, wdog_nxt;
  logic [omt_pkg::NumMatch-1:0] hit;
  logic [omt_pkg::DataW-1:0]    rd_data;
  logic [omt_pkg::MatchIdxW-1:0] sel;

  assign sel = item.reg_index[omt_pkg::MatchIdxW-1:0];

  always_comb begin
    for (int i = 0; i < omt_pkg::NumMatch; i++) begin
      hit[i] = irq_en_r[i] && (match_r[i] == count_r);
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    irq_en_nxt = irq_en_r;
    wdog_nxt   = wdog_r;
    rd_data    = '0;
    for (int i = 0; i < omt_pkg::NumMatch; i++) begin
      match_nxt[i] = match_r[i];
    end
    case (item.mode)
      omt_pkg::MODE_TICK: begin
        status_nxt = status_r | hit;
        count_nxt  = count_r + omt_pkg::DataW'(1);
      end
      omt_pkg::MODE_READ: begin
        case (item.reg_index)
          omt_pkg::REG_MATCH0, omt_pkg::REG_MATCH1,
          omt_pkg::REG_MATCH2, omt_pkg::REG_MATCH3: rd_data = match_r[sel];
          omt_pkg::REG_COUNT:  rd_data = count_r;
          omt_pkg::REG_STATUS: rd_data = {{(omt_pkg::DataW-omt_pkg::NumMatch){1'b0}}, status_r};
          omt_pkg::REG_WDOG:   rd_data = {{(omt_pkg::DataW-1){1'b0}}, wdog_r};
          default:             rd_data = {{(omt_pkg::DataW-omt_pkg::NumMatch){1'b0}}, irq_en_r};
        endcase
      end
      omt_pkg::MODE_WRITE: begin
        case (item.reg_index)
          omt_pkg::REG_MATCH0, omt_pkg::REG_MATCH1,
          omt_pkg::REG_MATCH2, omt_pkg::REG_MATCH3: match_nxt[sel] = item.write_data;
          omt_pkg::REG_COUNT:  count_nxt = item.write_data;
          omt_pkg::REG_STATUS: begin
            status_nxt = status_r & ~(item.write_data[omt_pkg::NumMatch-1:0] & omt_pkg::LOW4_MASK);
          end
          omt_pkg::REG_WDOG:   wdog_nxt = wdog_r | item.write_data[0];
          default:             irq_en_nxt = item.write_data[omt_pkg::NumMatch-1:0];
        endcase
      end
      default: begin
        // software reset keeps status, counter and match values
        wdog_nxt   = 1'b0;
        irq_en_nxt = '0;
      end
    endcase
  end

  assign result.read_data    = rd_data;
  assign result.match_status = status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      status_r <= '0;
      irq_en_r <= '0;
      wdog_r   <= 1'b0;
      for (int i = 0; i < omt_pkg::NumMatch; i++) begin
        match_r[i] <= '0;
      end
    end else if (item_fire) begin
      count_r  <= count_nxt;
      status_r <= status_nxt;
      irq_en_r <= irq_en_nxt;
      wdog_r   <= wdog_nxt;
      for (int i = 0; i < omt_pkg::NumMatch; i++) begin
        match_r[i] <= match_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/os_match_timer_registers_top.sv
// top level of the os match timer: input register, register file, result register
// an accepted item is registered in the input stage, and its result in the result register
// throughput: one item per cycle; in_ready drops only when both stages hold items
// and out_ready is low
// reset: synchronous active-low rst_n clears both stage valids, the counter,
// match registers, status, interrupt enable and watchdog enable
`default_nettype none

module os_match_timer_registers_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [2:0]  in_reg_index,
  input  wire logic [31:0] in_write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_read_data,
  output logic [3:0]       out_match_status
);

  logic              s1_valid_r;
  omt_pkg::item_t    s1_item_r;
  logic              s1_adv;
  logic              out_valid_r;
  omt_pkg::result_t  out_res_r;
  omt_pkg::result_t  result;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.mode       <= omt_pkg::mode_t'(in_mode);
      s1_item_r.reg_index  <= in_reg_index;
      s1_item_r.write_data <= in_write_data;
    end
  end

  omt_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (s1_adv),
    .item      (s1_item_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_res_r.read_data;
  assign out_match_status = out_res_r.match_status;

endmodule

`default_nettype wire

// File: hw/rtl/omt_checker.sv
// port-level checker for the os match timer, bound to the top level
`default_nettype none

module omt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_read_data,
  input wire logic [3:0]  out_match_status
);

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_match_status))
    else $error("stalled result changed");

  // with no result waiting the block always takes an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty result stage");

  // an item taken during a stall fills the input stage
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_valid && !out_ready && in_valid && in_ready)
      && out_valid && !out_ready |-> !in_ready)
    else $error("in_ready high with both stages full");

endmodule

bind os_match_timer_registers_top omt_checker u_omt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_read_data    (out_read_data),
  .out_match_status (out_match_status)
);

`default_nettype wire
